FILE: rtl/core/rbhs_pkg.sv
// rbhs_pkg: shared types and constants for the bind-and-hop sequencer
// no dependencies; imported by rbhs_link_codes and the top level
package rbhs_pkg;

    typedef enum logic [3:0] {
        ST_BIND      = 4'd0,
        ST_BIND_SEND = 4'd1,
        ST_LISTEN    = 4'd2,
        ST_CHECK     = 4'd3,
        ST_ACK0      = 4'd4,
        ST_ACK1      = 4'd5,
        ST_ACK2      = 4'd6,
        ST_ACK3      = 4'd7,
        ST_ACK4      = 4'd8,
        ST_ACK5      = 4'd9,
        ST_CHANSEL   = 4'd10,
        ST_HOP1      = 4'd11,
        ST_HOP2      = 4'd12,
        ST_HOP3      = 4'd13,
        ST_HOP4      = 4'd14
    } rbhs_state_t;

    typedef enum logic [2:0] {
        ACT_WAIT_TX   = 3'd0,
        ACT_SEND_BIND = 3'd1,
        ACT_LISTEN    = 3'd2,
        ACT_ACK_PREP  = 3'd3,
        ACT_RETRY     = 3'd4,
        ACT_SEND_ACK  = 3'd5,
        ACT_SEND_DATA = 3'd6,
        ACT_RESTARTED = 3'd7
    } rbhs_action_t;

    typedef enum logic [2:0] {
        CFG_START_BIND = 3'd0,
        CFG_RADIO_ID   = 3'd1,
        CFG_HOP_A      = 3'd2,
        CFG_HOP_B      = 3'd3,
        CFG_HOP_C      = 3'd4
    } rbhs_cfg_idx_t;

    typedef struct packed {
        logic [4:0]  sop_index;
        logic [15:0] crc_seed;
    } rbhs_link_t;

    typedef struct packed {
        rbhs_action_t action;
        logic [6:0]   rf_channel;
        logic         transmit_mode;
        logic [4:0]   packet_length;
        logic [15:0]  delay_us;
        logic         new_link_codes;
        logic [4:0]   sop_index;
        logic [15:0]  crc_seed;
        logic         refresh_payload;
        logic         bind_active;
    } rbhs_result_t;

    localparam logic [6:0]  CH_BIND   = 7'h52;
    localparam logic [6:0]  CH_LISTEN = 7'h53;
    localparam logic [6:0]  CH_ACK    = 7'h54;
    localparam logic [6:0]  HOP_RESET = 7'd8;

    localparam logic [7:0]  RX_GOOD_MASK  = 8'h1a;
    localparam logic [7:0]  RX_LEN_BIND   = 8'h0f;
    localparam logic [7:0]  RX_TYPE_BIND  = 8'h03;
    localparam logic [7:0]  TX_DONE_MASK  = 8'h06;

    localparam logic [4:0]  LEN_BIND = 5'd9;
    localparam logic [4:0]  LEN_ACK  = 5'd15;
    localparam logic [4:0]  LEN_DATA = 5'd16;

    localparam logic [15:0] DLY_RESTART  = 16'd2400;
    localparam logic [15:0] DLY_BIND     = 16'd3000;
    localparam logic [15:0] DLY_LISTEN   = 16'd30000;
    localparam logic [15:0] DLY_ACK_PREP = 16'd2000;
    localparam logic [15:0] DLY_RETRY    = 16'd500;
    localparam logic [15:0] DLY_ACK      = 16'd4600;
    localparam logic [15:0] DLY_HOP      = 16'd3550;
    localparam logic [15:0] DLY_FRAME    = 16'd13900;

    localparam logic [7:0]  SOP_TABLE_SIZE = 8'd19;

endpackage

FILE: rtl/core/radio_bind_and_hop_sequencer_unit.sv
// radio_bind_and_hop_sequencer_unit: top level of the bind-and-hop sequencer
// depends on rbhs_pkg and rbhs_link_codes
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  s_       | s_valid / s_ready    | kind, tx/rx irq status, rx header, echo id
//  m_       | m_valid / m_ready    | action, channel, mode, length, delay, codes
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one event per clock when not stalled: decision logic sits between the state
// and the output register, so a beat's result shows the next cycle
// s_ready is low only while a held result is not taken (m_ready low)
// reset clears state to data channel select, binding flag and m_valid
// config registers are always ready
module radio_bind_and_hop_sequencer_unit import rbhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_tx_irq_status,
    input  logic [7:0]  s_rx_irq_status,
    input  logic [7:0]  s_rx_length,
    input  logic [7:0]  s_rx_count,
    input  logic [7:0]  s_rx_packet_type,
    input  logic [47:0] s_rx_echo_id,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [6:0]  m_rf_channel,
    output logic        m_transmit_mode,
    output logic [4:0]  m_packet_length,
    output logic [15:0] m_delay_us,
    output logic        m_new_link_codes,
    output logic [4:0]  m_sop_index,
    output logic [15:0] m_crc_seed,
    output logic        m_refresh_payload,
    output logic        m_bind_active
);

    logic         start_bind_reg;
    logic [47:0]  radio_id_reg;
    logic [6:0]   hop_a_reg, hop_b_reg, hop_c_reg;

    rbhs_state_t  state_reg, state_next;
    logic         bind_reg, bind_next;
    logic         m_valid_reg;
    rbhs_result_t res_reg, res_next;

    rbhs_link_t   link;
    logic         s_fire;
    logic         tx_done;
    logic         reply_good;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_bind_reg <= 1'b0;
            radio_id_reg   <= '0;
            hop_a_reg      <= HOP_RESET;
            hop_b_reg      <= HOP_RESET;
            hop_c_reg      <= HOP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_BIND: start_bind_reg <= cfg_data[0];
                CFG_RADIO_ID:   radio_id_reg   <= cfg_data;
                CFG_HOP_A:      hop_a_reg      <= cfg_data[6:0];
                CFG_HOP_B:      hop_b_reg      <= cfg_data[6:0];
                CFG_HOP_C:      hop_c_reg      <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rbhs_link_codes u_link_codes (
        .radio_id (radio_id_reg),
        .link     (link)
    );

    assign tx_done    = (s_tx_irq_status & TX_DONE_MASK) != 8'd0;
    assign reply_good = ((s_rx_irq_status & RX_GOOD_MASK) == RX_GOOD_MASK)
                        && (s_rx_length == RX_LEN_BIND)
                        && (s_rx_count == RX_LEN_BIND)
                        && (s_rx_packet_type == RX_TYPE_BIND)
                        && (s_rx_echo_id == radio_id_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        bind_next  = bind_reg;
        if (s_kind) begin
            state_next = start_bind_reg ? ST_BIND : ST_CHANSEL;
            if (start_bind_reg) begin
                bind_next = 1'b1;
            end
        end else begin
            unique case (state_reg)
                ST_BIND: begin
                    bind_next  = 1'b1;
                    state_next = ST_LISTEN;
                end
                ST_BIND_SEND: state_next = ST_LISTEN;
                ST_LISTEN: begin
                    if (tx_done) begin
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK: state_next = reply_good ? ST_ACK0 : ST_BIND_SEND;
                ST_ACK0, ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4, ST_ACK5,
                ST_HOP1, ST_HOP2, ST_HOP3:
                    state_next = rbhs_state_t'(state_reg + 4'd1);
                ST_CHANSEL: begin
                    bind_next  = 1'b0;
                    state_next = ST_HOP2;
                end
                ST_HOP4: state_next = ST_HOP1;
                default: ;
            endcase
        end
    end

    // result fields
    always_comb begin
        res_next             = '0;
        res_next.action      = ACT_WAIT_TX;
        res_next.bind_active = bind_next;
        if (s_kind) begin
            res_next.action   = ACT_RESTARTED;
            res_next.delay_us = DLY_RESTART;
        end else begin
            unique case (state_reg)
                ST_BIND, ST_BIND_SEND: begin
                    res_next.action        = ACT_SEND_BIND;
                    res_next.rf_channel    = CH_BIND;
                    res_next.transmit_mode = 1'b1;
                    res_next.packet_length = LEN_BIND;
                    res_next.delay_us      = DLY_BIND;
                end
                ST_LISTEN: begin
                    if (tx_done) begin
                        res_next.action     = ACT_LISTEN;
                        res_next.rf_channel = CH_LISTEN;
                        res_next.delay_us   = DLY_LISTEN;
                    end else begin
                        // radio still sending: poll again
                        res_next.action        = ACT_WAIT_TX;
                        res_next.rf_channel    = CH_BIND;
                        res_next.transmit_mode = 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (reply_good) begin
                        res_next.action        = ACT_ACK_PREP;
                        res_next.rf_channel    = CH_ACK;
                        res_next.transmit_mode = 1'b1;
                        res_next.delay_us      = DLY_ACK_PREP;
                    end else begin
                        res_next.action     = ACT_RETRY;
                        res_next.rf_channel = CH_LISTEN;
                        res_next.delay_us   = DLY_RETRY;
                    end
                end
                ST_ACK0, ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4, ST_ACK5: begin
                    res_next.action        = ACT_SEND_ACK;
                    res_next.rf_channel    = CH_ACK;
                    res_next.transmit_mode = 1'b1;
                    res_next.packet_length = LEN_ACK;
                    res_next.delay_us      = DLY_ACK;
                end
                ST_CHANSEL, ST_HOP1, ST_HOP2, ST_HOP3, ST_HOP4: begin
                    res_next.action        = ACT_SEND_DATA;
                    res_next.transmit_mode = 1'b1;
                    res_next.packet_length = LEN_DATA;
                    res_next.delay_us      = (state_reg == ST_HOP4) ? DLY_FRAME : DLY_HOP;
                    if (state_reg == ST_HOP2) begin
                        res_next.rf_channel = hop_b_reg;
                    end else if (state_reg == ST_HOP3) begin
                        res_next.rf_channel = hop_c_reg;
                    end else begin
                        res_next.rf_channel = hop_a_reg;
                    end
                    // channel select falls through into the first hop slot
                    res_next.refresh_payload = (state_reg == ST_CHANSEL)
                                               || (state_reg == ST_HOP1);
                    if (state_reg == ST_CHANSEL) begin
                        res_next.new_link_codes = 1'b1;
                        res_next.sop_index      = link.sop_index;
                        res_next.crc_seed       = link.crc_seed;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CHANSEL;
            bind_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                bind_reg    <= bind_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_action          = res_reg.action;
    assign m_rf_channel      = res_reg.rf_channel;
    assign m_transmit_mode   = res_reg.transmit_mode;
    assign m_packet_length   = res_reg.packet_length;
    assign m_delay_us        = res_reg.delay_us;
    assign m_new_link_codes  = res_reg.new_link_codes;
    assign m_sop_index       = res_reg.sop_index;
    assign m_crc_seed        = res_reg.crc_seed;
    assign m_refresh_payload = res_reg.refresh_payload;
    assign m_bind_active     = res_reg.bind_active;

    // link codes only come with the first data beat, binding cleared
    a_codes_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_link_codes) |->
            (m_action == ACT_SEND_DATA && m_refresh_payload && !m_bind_active))
        else $error("link codes outside data entry");

    // a wait-tx poll leaves the state alone
    a_poll_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_kind && state_reg == ST_LISTEN && !tx_done) |=>
            (state_reg == ST_LISTEN))
        else $error("state moved on a tx poll");

    // a held result keeps the input stalled
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted over a held result");

    // binding flag only set through a bind restart or the bind state
    a_bind_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(bind_reg) |->
            ($past(s_kind) || $past(state_reg) == ST_BIND))
        else $error("binding flag set unexpectedly");

    // data mode never runs with binding active after channel select
    a_hop_unbound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOP1 || state_reg == ST_HOP2 || state_reg == ST_HOP3
         || state_reg == ST_HOP4) |-> !bind_reg || $past(s_fire))
        else $error("hopping while bound flag set");

endmodule

FILE: rtl/core/rbhs_link_codes.sv
// rbhs_link_codes: derives the sop code index and crc seed from the radio id
// depends on rbhs_pkg
module rbhs_link_codes import rbhs_pkg::*; (
    input  logic [47:0] radio_id,
    output rbhs_link_t  link
);

    logic [7:0]  id0, id1, id2, id3, id4, id5;
    logic [7:0]  sum;
    logic [12:0] quot_prod;
    logic [3:0]  quot;
    logic [7:0]  quot_times;
    logic [7:0]  rem;
    logic [7:0]  seed_lo, seed_hi;

    assign id0 = radio_id[7:0];
    assign id1 = radio_id[15:8];
    assign id2 = radio_id[23:16];
    assign id3 = radio_id[31:24];
    assign id4 = radio_id[39:32];
    assign id5 = radio_id[47:40];

    assign sum = id0 + id1 + id2 + id3 - id5;

    // sum / 19 as sum * 27 / 512, exact for all 8-bit sums
    assign quot_prod  = {5'd0, sum} * 13'd27;
    assign quot       = quot_prod[12:9];
    assign quot_times = {4'd0, quot} * SOP_TABLE_SIZE;
    assign rem        = sum - quot_times;

    assign seed_lo = id1 - id4 + id5;
    assign seed_hi = id2 + id3 - id4 + id5;

    assign link.sop_index = rem[4:0];
    assign link.crc_seed  = {seed_hi, seed_lo};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for radio_bind_and_hop_sequencer_unit (needs rbhs_pkg)
// a local protocol tracker predicts each result beat; stimulus mixes bind and hop traffic
module testbench;
    import rbhs_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_irq;
        logic [7:0]  rx_irq;
        logic [7:0]  rx_len;
        logic [7:0]  rx_cnt;
        logic [7:0]  rx_type;
        logic [47:0] echo_id;
    } radio_event_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [7:0]  s_tx_irq_status;
    logic [7:0]  s_rx_irq_status;
    logic [7:0]  s_rx_length;
    logic [7:0]  s_rx_count;
    logic [7:0]  s_rx_packet_type;
    logic [47:0] s_rx_echo_id;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_action;
    logic [6:0]  m_rf_channel;
    logic        m_transmit_mode;
    logic [4:0]  m_packet_length;
    logic [15:0] m_delay_us;
    logic        m_new_link_codes;
    logic [4:0]  m_sop_index;
    logic [15:0] m_crc_seed;
    logic        m_refresh_payload;
    logic        m_bind_active;

    // protocol tracker state and its copy of the registers
    rbhs_state_t trk_state;
    logic        trk_binding;
    logic        trk_start_bind;
    logic [47:0] trk_radio_id;
    logic [6:0]  trk_hop_a;
    logic [6:0]  trk_hop_b;
    logic [6:0]  trk_hop_c;

    rbhs_result_t pending_actions[$];
    int           failures;
    int           idle_cycles;
    bit           steady;
    bit           holdoff_req;
    int           holdoff_len;

    radio_bind_and_hop_sequencer_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_tx_irq_status   (s_tx_irq_status),
        .s_rx_irq_status   (s_rx_irq_status),
        .s_rx_length       (s_rx_length),
        .s_rx_count        (s_rx_count),
        .s_rx_packet_type  (s_rx_packet_type),
        .s_rx_echo_id      (s_rx_echo_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_rf_channel      (m_rf_channel),
        .m_transmit_mode   (m_transmit_mode),
        .m_packet_length   (m_packet_length),
        .m_delay_us        (m_delay_us),
        .m_new_link_codes  (m_new_link_codes),
        .m_sop_index       (m_sop_index),
        .m_crc_seed        (m_crc_seed),
        .m_refresh_payload (m_refresh_payload),
        .m_bind_active     (m_bind_active)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // one protocol decision per event; updates tracker state
    task automatic advance_sequencer(input radio_event_t ev, output rbhs_result_t r);
        logic [7:0]  b [6];
        logic [7:0]  sop_sum;
        logic [7:0]  crc_lo;
        logic [7:0]  crc_hi;
        logic        good;
        rbhs_state_t st;
        r = '0;
        st = trk_state;
        if (ev.kind) begin
            trk_state = trk_start_bind ? ST_BIND : ST_CHANSEL;
            if (trk_start_bind)
                trk_binding = 1'b1;
            r.action = ACT_RESTARTED;
            r.delay_us = DLY_RESTART;
        end else if (st <= ST_BIND_SEND) begin
            if (st == ST_BIND)
                trk_binding = 1'b1;
            r.action = ACT_SEND_BIND;
            r.rf_channel = CH_BIND;
            r.transmit_mode = 1'b1;
            r.packet_length = LEN_BIND;
            r.delay_us = DLY_BIND;
            trk_state = ST_LISTEN;
        end else if (st == ST_LISTEN) begin
            if ((ev.tx_irq & TX_DONE_MASK) == 8'h00) begin
                // tx not done yet: poll again, state held
                r.action = ACT_WAIT_TX;
                r.rf_channel = CH_BIND;
                r.transmit_mode = 1'b1;
            end else begin
                r.action = ACT_LISTEN;
                r.rf_channel = CH_LISTEN;
                r.delay_us = DLY_LISTEN;
                trk_state = ST_CHECK;
            end
        end else if (st == ST_CHECK) begin
            good = ((ev.rx_irq & RX_GOOD_MASK) == RX_GOOD_MASK) && (ev.rx_len == RX_LEN_BIND)
                && (ev.rx_cnt == RX_LEN_BIND) && (ev.rx_type == RX_TYPE_BIND)
                && (ev.echo_id == trk_radio_id);
            if (good) begin
                r.action = ACT_ACK_PREP;
                r.rf_channel = CH_ACK;
                r.transmit_mode = 1'b1;
                r.delay_us = DLY_ACK_PREP;
                trk_state = ST_ACK0;
            end else begin
                r.action = ACT_RETRY;
                r.rf_channel = CH_LISTEN;
                r.delay_us = DLY_RETRY;
                trk_state = ST_BIND_SEND;
            end
        end else if (st >= ST_ACK0 && st <= ST_ACK5) begin
            r.action = ACT_SEND_ACK;
            r.rf_channel = CH_ACK;
            r.transmit_mode = 1'b1;
            r.packet_length = LEN_ACK;
            r.delay_us = DLY_ACK;
            trk_state = rbhs_state_t'(st + 4'd1);
        end else if (st >= ST_CHANSEL && st <= ST_HOP4) begin
            if (st == ST_CHANSEL) begin
                for (int k = 0; k < 6; k++)
                    b[k] = trk_radio_id[8*k +: 8];
                trk_binding = 1'b0;
                // byte sums wrap at 8 bits
                sop_sum = b[0] + b[1] + b[2] + b[3] - b[5];
                crc_lo = b[1] - b[4] + b[5];
                crc_hi = b[2] + b[3] - b[4] + b[5];
                r.new_link_codes = 1'b1;
                r.sop_index = 5'(sop_sum % SOP_TABLE_SIZE);
                r.crc_seed = {crc_hi, crc_lo};
                st = ST_HOP1;
            end
            r.refresh_payload = (st == ST_HOP1);
            case (st)
                ST_HOP1, ST_HOP4: r.rf_channel = trk_hop_a;
                ST_HOP2:          r.rf_channel = trk_hop_b;
                default:          r.rf_channel = trk_hop_c;
            endcase
            r.action = ACT_SEND_DATA;
            r.transmit_mode = 1'b1;
            r.packet_length = LEN_DATA;
            if (st == ST_HOP4) begin
                r.delay_us = DLY_FRAME;
                trk_state = ST_HOP1;
            end else begin
                r.delay_us = DLY_HOP;
                trk_state = rbhs_state_t'(st + 4'd1);
            end
        end
        r.bind_active = trk_binding;
    endtask

    function automatic logic [47:0] rand48();
        logic [31:0] upper;
        logic [31:0] lower;
        upper = $urandom;
        lower = $urandom;
        return {upper[15:0], lower};
    endfunction

    function automatic radio_event_t noise_event();
        radio_event_t ev;
        ev.kind = 1'b0;
        ev.tx_irq = 8'($urandom);
        ev.rx_irq = 8'($urandom);
        ev.rx_len = 8'($urandom);
        ev.rx_cnt = 8'($urandom);
        ev.rx_type = 8'($urandom);
        ev.echo_id = rand48();
        return ev;
    endfunction

    // bind reply header; a bad one breaks exactly one of the checks
    function automatic radio_event_t reply_event(input bit good);
        radio_event_t ev;
        ev = noise_event();
        ev.rx_irq = ev.rx_irq | RX_GOOD_MASK;
        ev.rx_len = RX_LEN_BIND;
        ev.rx_cnt = RX_LEN_BIND;
        ev.rx_type = RX_TYPE_BIND;
        ev.echo_id = trk_radio_id;
        if (!good) begin
            case ($urandom_range(4))
                0: begin
                    case ($urandom_range(2))
                        0:       ev.rx_irq = ev.rx_irq & ~8'h02;
                        1:       ev.rx_irq = ev.rx_irq & ~8'h08;
                        default: ev.rx_irq = ev.rx_irq & ~8'h10;
                    endcase
                end
                1: ev.rx_len = ev.rx_len ^ 8'($urandom_range(255, 1));
                2: ev.rx_cnt = ev.rx_cnt ^ 8'($urandom_range(255, 1));
                3: ev.rx_type = ev.rx_type ^ 8'($urandom_range(255, 1));
                default: ev.echo_id = ev.echo_id ^ (rand48() | 48'h1);
            endcase
        end
        return ev;
    endfunction

    // mostly well-formed traffic for the current protocol state, some noise
    function automatic radio_event_t random_event();
        radio_event_t ev;
        int pick;
        pick = $urandom_range(99);
        ev = noise_event();
        if (pick < 3) begin
            ev.kind = 1'b1;
        end else if (pick >= 10 && trk_state == ST_LISTEN) begin
            if (pick < 80)
                ev.tx_irq = ev.tx_irq | (8'h02 << $urandom_range(1));
            else
                ev.tx_irq = ev.tx_irq & ~TX_DONE_MASK;
        end else if (pick >= 10 && trk_state == ST_CHECK) begin
            ev = reply_event(pick < 75);
        end
        return ev;
    endfunction

    function automatic logic [6:0] hop_pick();
        if ($urandom_range(9) == 0)
            return 7'($urandom);
        return 7'($urandom_range(77, 8));
    endfunction

    function automatic void check_field(input string field, input logic [47:0] want,
                                        input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    task automatic send_event(input radio_event_t ev);
        rbhs_result_t r;
        // short gaps: an idle stretch before about 3 beats in a hundred, none in steady mode
        if (!steady && $urandom_range(99) < 3) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= ev.kind;
        s_tx_irq_status <= ev.tx_irq;
        s_rx_irq_status <= ev.rx_irq;
        s_rx_length <= ev.rx_len;
        s_rx_count <= ev.rx_cnt;
        s_rx_packet_type <= ev.rx_type;
        s_rx_echo_id <= ev.echo_id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_sequencer(ev, r);
        pending_actions.push_back(r);
    endtask

    // sender stops until every expected beat has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input rbhs_cfg_idx_t idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_START_BIND: trk_start_bind = val[0];
            CFG_RADIO_ID:   trk_radio_id = val;
            CFG_HOP_A:      trk_hop_a = val[6:0];
            CFG_HOP_B:      trk_hop_b = val[6:0];
            CFG_HOP_C:      trk_hop_c = val[6:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic sb, input logic [47:0] id,
                               input logic [6:0] a, input logic [6:0] b, input logic [6:0] c);
        settle();
        write_register(CFG_START_BIND, {47'd0, sb});
        write_register(CFG_RADIO_ID, id);
        write_register(CFG_HOP_A, {41'd0, a});
        write_register(CFG_HOP_B, {41'd0, b});
        write_register(CFG_HOP_C, {41'd0, c});
    endtask

    // reset defaults: straight into link codes for id 0, then hops on channel 8
    task automatic test_power_on_hops();
        repeat (5) send_event(noise_event());
    endtask

    task automatic test_bind_handshake();
        radio_event_t ev;
        load_config(1'b1, 48'hffff_ffff_ffff, 7'd77, 7'd127, 7'd0);
        ev = noise_event();
        ev.kind = 1'b1;
        send_event(ev);
        send_event(noise_event());
        ev = noise_event();
        ev.tx_irq = 8'hf9;
        send_event(ev);
        ev = noise_event();
        ev.tx_irq = 8'h02;
        send_event(ev);
        ev = reply_event(1'b1);
        ev.rx_type = 8'h04;
        send_event(ev);
        send_event(noise_event());
        ev = noise_event();
        ev.tx_irq = 8'h04;
        send_event(ev);
        send_event(reply_event(1'b1));
        // six acks, link codes, then the remaining hop slots
        repeat (10) send_event(noise_event());
    endtask

    task automatic test_random_traffic();
        logic [47:0] id;
        for (int phase = 0; phase < 6; phase++) begin
            id = rand48();
            if (phase == 1)
                id = '0;
            else if (phase == 2)
                id = '1;
            load_config(phase % 2 == 0, id, hop_pick(), hop_pick(), hop_pick());
            steady = (phase == 3);
            for (int n = 0; n < 280; n++)
                send_event(random_event());
            steady = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        load_config(1'b1, rand48(), 7'd8, 7'd40, 7'd77);
        holdoff_len = 150;
        holdoff_req = 1'b1;
        for (int n = 0; n < 60; n++)
            send_event(random_event());
        settle();
        for (int n = 0; n < 40; n++)
            send_event(random_event());
    endtask

    initial begin : receiver
        int holdoff_left;
        holdoff_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                holdoff_left = holdoff_len;
                holdoff_req = 1'b0;
            end
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
                holdoff_left--;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 9);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rbhs_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_actions.size() == 0) begin
                $display("%0t: result beat with nothing expected, action %0d", $time, m_action);
                failures++;
            end else begin
                want = pending_actions.pop_front();
                check_field("action", want.action, m_action);
                check_field("rf_channel", want.rf_channel, m_rf_channel);
                check_field("transmit_mode", want.transmit_mode, m_transmit_mode);
                check_field("packet_length", want.packet_length, m_packet_length);
                check_field("delay_us", want.delay_us, m_delay_us);
                check_field("new_link_codes", want.new_link_codes, m_new_link_codes);
                check_field("sop_index", want.sop_index, m_sop_index);
                check_field("crc_seed", want.crc_seed, m_crc_seed);
                check_field("refresh_payload", want.refresh_payload, m_refresh_payload);
                check_field("bind_active", want.bind_active, m_bind_active);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_START_BIND;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_kind <= 1'b0;
        s_tx_irq_status <= '0;
        s_rx_irq_status <= '0;
        s_rx_length <= '0;
        s_rx_count <= '0;
        s_rx_packet_type <= '0;
        s_rx_echo_id <= '0;
        idle_cycles <= 0;
        failures = 0;
        steady = 1'b0;
        holdoff_req = 1'b0;
        holdoff_len = 0;
        trk_state = ST_CHANSEL;
        trk_binding = 1'b0;
        trk_start_bind = 1'b0;
        trk_radio_id = '0;
        trk_hop_a = HOP_RESET;
        trk_hop_b = HOP_RESET;
        trk_hop_c = HOP_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_power_on_hops();
        test_bind_handshake();
        test_random_traffic();
        test_backpressure();
        settle();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: radio_bind_and_hop_sequencer_unit.f
rtl/core/rbhs_pkg.sv
rtl/core/rbhs_link_codes.sv
rtl/core/radio_bind_and_hop_sequencer_unit.sv
verif/testbench.sv
